// ----- hdl/cartesian_to_spherical_top_assert.svh -----
// assertion macros for cartesian_to_spherical_top, the file that checks itself
`ifndef CARTESIAN_TO_SPHERICAL_TOP_ASSERT_SVH
`define CARTESIAN_TO_SPHERICAL_TOP_ASSERT_SVH

// condition implies consequence in the same cycle
`define CTS_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// condition implies consequence in the next cycle
`define CTS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hdl/cts_pkg.sv -----
package cts_pkg;

	localparam int COORD_WIDTH_DEF  = 24;
	localparam int ANGLE_STAGES_DEF = 24;
	localparam int GUARD_BITS       = 8;
	localparam int ANG_W            = 34;
	localparam int ZEN_W            = 23;
	localparam int AZ_W             = 24;

	localparam logic signed [ANG_W-1:0] HALF_PI_A = 34'sh040000000;
	localparam logic signed [ANG_W-1:0] OUT_PI_A  = 34'sd4194304;

	typedef struct packed {
		logic full;
		logic not_empty;
	} cts_fifo_stat_t;

	// arctangent of 2^-i, pi = 2^31
	function automatic logic signed [ANG_W-1:0] atan_val(input int idx);
		unique case (idx)
			0:  return 34'sh020000000;
			1:  return 34'sh012E4051E;
			2:  return 34'sh009FB385B;
			3:  return 34'sh0051111D4;
			4:  return 34'sh0028B0D43;
			5:  return 34'sh00145D7E1;
			6:  return 34'sh000A2F61E;
			7:  return 34'sh000517C55;
			8:  return 34'sh00028BE53;
			9:  return 34'sh000145F2F;
			10: return 34'sh0000A2F98;
			11: return 34'sh0000517CC;
			12: return 34'sh000028BE6;
			13: return 34'sh0000145F3;
			14: return 34'sh00000A2FA;
			15: return 34'sh00000517D;
			16: return 34'sh0000028BE;
			17: return 34'sh00000145F;
			18: return 34'sh000000A30;
			19: return 34'sh000000518;
			20: return 34'sh00000028C;
			21: return 34'sh000000146;
			22: return 34'sh0000000A3;
			23: return 34'sh000000051;
			24: return 34'sh000000029;
			25: return 34'sh000000014;
			26: return 34'sh00000000A;
			27: return 34'sh000000005;
			28: return 34'sh000000003;
			29: return 34'sh000000001;
			30: return 34'sh000000001;
			default: return '0;
		endcase
	endfunction

endpackage

// ----- hdl/cts_sqrt_pipe.sv -----
// integer square root, one result bit per stage, remainder kept
module cts_sqrt_pipe import cts_pkg::*; #(
	parameter int IN_W   = 66,
	parameter int SIDE_W = 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  logic [IN_W-1:0]   radicand,
	input  logic [SIDE_W-1:0] side_in,
	output logic              out_valid,
	output logic [IN_W/2-1:0] root,
	output logic [IN_W/2+1:0] rem,
	output logic [SIDE_W-1:0] side_out
);

	localparam int RW = IN_W / 2;

	logic [IN_W-1:0]   rad_s  [RW];
	logic [RW-1:0]     root_s [RW];
	logic [RW+1:0]     rem_s  [RW];
	logic [SIDE_W-1:0] side_s [RW];
	logic              v_s    [RW];

	for (genvar k = 0; k < RW; k++) begin : g_stage
		logic [IN_W-1:0]   rad_in;
		logic [RW-1:0]     root_in;
		logic [RW+1:0]     rem_in;
		logic [SIDE_W-1:0] side_i;
		logic              v_in;
		logic [RW+1:0]     rem_sh;
		logic [RW+1:0]     trial;
		logic              ge;

		if (k == 0) begin : g_first
			assign rad_in  = radicand;
			assign root_in = '0;
			assign rem_in  = '0;
			assign side_i  = side_in;
			assign v_in    = in_valid;
		end else begin : g_next
			assign rad_in  = rad_s[k-1];
			assign root_in = root_s[k-1];
			assign rem_in  = rem_s[k-1];
			assign side_i  = side_s[k-1];
			assign v_in    = v_s[k-1];
		end

		// earlier remainders stay below 2^RW
		assign rem_sh = {rem_in[RW-1:0], rad_in[IN_W-1 -: 2]};
		assign trial  = {root_in, 2'b01};
		assign ge     = (rem_sh >= trial);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (en) begin
				v_s[k] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rad_s[k]  <= rad_in << 2;
				root_s[k] <= {root_in[RW-2:0], ge};
				rem_s[k]  <= ge ? (rem_sh - trial) : rem_sh;
				side_s[k] <= side_i;
			end
		end
	end

	assign out_valid = v_s[RW-1];
	assign root      = root_s[RW-1];
	assign rem       = rem_s[RW-1];
	assign side_out  = side_s[RW-1];

endmodule

// ----- hdl/cts_cordic_pipe.sv -----
// vectoring cordic: pre-rotation stage, then one micro-rotation per stage
module cts_cordic_pipe import cts_pkg::*; #(
	parameter int DW     = 35,
	parameter int STAGES = 24,
	parameter int SIDE_W = 1
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    en,
	input  logic                    in_valid,
	input  logic signed [DW-1:0]    x_in,
	input  logic signed [DW-1:0]    y_in,
	input  logic [SIDE_W-1:0]       side_in,
	output logic                    out_valid,
	output logic signed [ANG_W-1:0] angle,
	output logic [SIDE_W-1:0]       side_out
);

	logic signed [DW-1:0]    x_s    [STAGES+1];
	logic signed [DW-1:0]    y_s    [STAGES+1];
	logic signed [ANG_W-1:0] a_s    [STAGES+1];
	logic [SIDE_W-1:0]       side_s [STAGES+1];
	logic                    v_s    [STAGES+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else if (en) begin
			v_s[0] <= in_valid;
		end
	end

	// left half plane is turned by a quarter first
	always_ff @(posedge clk) begin
		if (en) begin
			side_s[0] <= side_in;
			if (!x_in[DW-1]) begin
				x_s[0] <= x_in;
				y_s[0] <= y_in;
				a_s[0] <= '0;
			end else if (!y_in[DW-1]) begin
				x_s[0] <= y_in;
				y_s[0] <= -x_in;
				a_s[0] <= HALF_PI_A;
			end else begin
				x_s[0] <= -y_in;
				y_s[0] <= x_in;
				a_s[0] <= -HALF_PI_A;
			end
		end
	end

	for (genvar k = 1; k <= STAGES; k++) begin : g_iter
		logic signed [DW-1:0] xs;
		logic signed [DW-1:0] ys;

		assign xs = x_s[k-1] >>> (k - 1);
		assign ys = y_s[k-1] >>> (k - 1);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (en) begin
				v_s[k] <= v_s[k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				side_s[k] <= side_s[k-1];
				if (!y_s[k-1][DW-1]) begin
					x_s[k] <= x_s[k-1] + ys;
					y_s[k] <= y_s[k-1] - xs;
					a_s[k] <= a_s[k-1] + atan_val(k - 1);
				end else begin
					x_s[k] <= x_s[k-1] - ys;
					y_s[k] <= y_s[k-1] + xs;
					a_s[k] <= a_s[k-1] - atan_val(k - 1);
				end
			end
		end
	end

	assign out_valid = v_s[STAGES];
	assign angle     = a_s[STAGES];
	assign side_out  = side_s[STAGES];

endmodule

// ----- hdl/cts_out_fifo.sv -----
// two-entry output buffer between the pipeline and the result stream
module cts_out_fifo import cts_pkg::*; #(
	parameter int DW = 73
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  logic [DW-1:0]  din,
	input  logic           pop_ready,
	output logic [DW-1:0]  dout,
	output cts_fifo_stat_t stat
);

	logic [DW-1:0] mem_q [2];
	logic          wr_q;
	logic          rd_q;
	logic [1:0]    cnt_q;
	logic          pop;

	assign stat.not_empty = (cnt_q != 2'd0);
	assign stat.full      = (cnt_q == 2'd2);
	assign pop            = stat.not_empty && pop_ready;
	assign dout           = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= din;
		end
	end

endmodule

// ----- hdl/cartesian_to_spherical_top.sv -----
// channel   dir  width                      content
// s_axis    in   COORD_WIDTH*3 to bytes     one point x, y, z
// m_axis    out  COORD_WIDTH+47 to bytes    radius, zenith, azimuth; tuser at origin
//
// one point per cycle while the output buffer is not full
// latency is set by the root stages for rho and the radius and the cordics after them
// arst_n clears all valid bits and the output buffer; data registers are not reset
// the whole pipeline holds while the two-entry output buffer is full
module cartesian_to_spherical_top import cts_pkg::*; #(
	parameter int COORD_WIDTH  = COORD_WIDTH_DEF,
	parameter int ANGLE_STAGES = ANGLE_STAGES_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_axis_tvalid,
	output logic                                 s_axis_tready,
	// x_coord, y_coord, z_coord
	input  logic [((3*COORD_WIDTH+7)/8)*8-1:0]   s_axis_tdata,
	output logic                                 m_axis_tvalid,
	input  logic                                 m_axis_tready,
	// radius, zenith_angle, azimuth_angle
	output logic [((COORD_WIDTH+47+7)/8)*8-1:0]  m_axis_tdata,
	// at_origin
	output logic                                 m_axis_tuser
);

	localparam int W      = COORD_WIDTH;
	localparam int IN_DW  = ((3*W+7)/8)*8;
	localparam int OUT_DW = ((W+47+7)/8)*8;
	localparam int SQ_W   = 2*W + 2*GUARD_BITS + 2;
	localparam int RW     = SQ_W / 2;
	localparam int CW     = W + GUARD_BITS + 3;
	localparam int SIDE_W = 3*W + 3;
	localparam int PAD_W  = OUT_DW - (W + ZEN_W + AZ_W);

	logic                en;
	cts_fifo_stat_t      fst;

	logic signed [W-1:0] x_in, y_in, z_in;

	logic                v_s1;
	logic [2*W-1:0]      xx_s1, yy_s1, zz_s1;
	logic signed [W-1:0] x_s1, y_s1, z_s1;

	logic                v_s2;
	logic [2*W:0]        sxy_s2;
	logic [2*W+1:0]      s_s2;
	logic signed [W-1:0] x_s2, y_s2, z_s2;
	logic                sxy_zero_s2, s_zero_s2, z_pos_s2;

	logic [2*W:0]        sxy_c;
	logic [2*W+1:0]      s_c;

	logic                rho_v, rad_v;
	logic [RW-1:0]       rho_root, rad_root;
	logic [RW+1:0]       rho_rem, rad_rem;
	logic [SIDE_W-1:0]   rho_side;
	logic                rad_side;

	logic signed [W-1:0] x_r, y_r, z_r;
	logic                sxy_zero_r, z_pos_r;
	logic [W:0]          r_round;
	logic [W-1:0]        r_sat;

	logic                az_v, zen_v;
	logic signed [ANG_W-1:0] az_ang, zen_ang;
	logic [W+1:0]        az_side;
	logic                zen_side;

	logic signed [ANG_W-1:0] az_sc, zen_sc, az_cl, zen_cl;
	logic [W-1:0]        radius_w;
	logic [ZEN_W-1:0]    zen_w;
	logic [AZ_W-1:0]     az_w;
	logic                origin_w;
	logic                push;
	logic [OUT_DW:0]     fifo_din, fifo_dout;

	logic [W-1:0]        radius_o;
	logic [ZEN_W-1:0]    zen_o;
	logic [AZ_W-1:0]     az_o;

	assign en            = !fst.full;
	assign s_axis_tready = en;

	assign x_in = s_axis_tdata[W-1:0];
	assign y_in = s_axis_tdata[2*W-1:W];
	assign z_in = s_axis_tdata[3*W-1:2*W];

	// stage 1: squares
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s1 <= s_axis_tvalid;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			xx_s1 <= x_in * x_in;
			yy_s1 <= y_in * y_in;
			zz_s1 <= z_in * z_in;
			x_s1  <= x_in;
			y_s1  <= y_in;
			z_s1  <= z_in;
		end
	end

	// stage 2: sums of squares and the special-case flags
	assign sxy_c = {1'b0, xx_s1} + {1'b0, yy_s1};
	assign s_c   = {1'b0, sxy_c} + {2'b0, zz_s1};

	always_ff @(posedge clk) begin
		if (en) begin
			sxy_s2      <= sxy_c;
			s_s2        <= s_c;
			x_s2        <= x_s1;
			y_s2        <= y_s1;
			z_s2        <= z_s1;
			sxy_zero_s2 <= (sxy_c == '0);
			s_zero_s2   <= (s_c == '0);
			z_pos_s2    <= !z_s1[W-1] && (z_s1 != '0);
		end
	end

	// rho with guard fraction bits, and the radius on the same stage count
	cts_sqrt_pipe #(.IN_W(SQ_W), .SIDE_W(SIDE_W)) u_rho_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (v_s2),
		.radicand ({1'b0, sxy_s2, {(2*GUARD_BITS){1'b0}}}),
		.side_in  ({z_s2, y_s2, x_s2, z_pos_s2, s_zero_s2, sxy_zero_s2}),
		.out_valid(rho_v),
		.root     (rho_root),
		.rem      (rho_rem),
		.side_out (rho_side)
	);

	cts_sqrt_pipe #(.IN_W(SQ_W), .SIDE_W(1)) u_rad_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (v_s2),
		.radicand ({{(2*GUARD_BITS){1'b0}}, s_s2}),
		.side_in  (s_zero_s2),
		.out_valid(rad_v),
		.root     (rad_root),
		.rem      (rad_rem),
		.side_out (rad_side)
	);

	assign sxy_zero_r = rho_side[0];
	assign z_pos_r    = rho_side[2];
	assign x_r        = rho_side[W+2:3];
	assign y_r        = rho_side[2*W+2:W+3];
	assign z_r        = rho_side[3*W+2:2*W+3];

	// round to nearest: remainder above the root means the upper half
	assign r_round = rad_root[W:0] + {{W{1'b0}}, (rad_rem > {2'b0, rad_root})};
	assign r_sat   = r_round[W] ? {W{1'b1}} : r_round[W-1:0];

	cts_cordic_pipe #(.DW(CW), .STAGES(ANGLE_STAGES), .SIDE_W(W+2)) u_az_cordic (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (rho_v && rad_v),
		.x_in     ({{3{x_r[W-1]}}, x_r, {GUARD_BITS{1'b0}}}),
		.y_in     ({{3{y_r[W-1]}}, y_r, {GUARD_BITS{1'b0}}}),
		.side_in  ({r_sat, z_pos_r, sxy_zero_r}),
		.out_valid(az_v),
		.angle    (az_ang),
		.side_out (az_side)
	);

	cts_cordic_pipe #(.DW(CW), .STAGES(ANGLE_STAGES), .SIDE_W(1)) u_zen_cordic (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (rho_v && rad_v),
		.x_in     ({{3{z_r[W-1]}}, z_r, {GUARD_BITS{1'b0}}}),
		.y_in     ({2'b0, rho_root}),
		.side_in  (rad_side),
		.out_valid(zen_v),
		.angle    (zen_ang),
		.side_out (zen_side)
	);

	// back to the output angle unit, rounded, then clamped
	assign az_sc  = (az_ang + 34'sd256) >>> 9;
	assign zen_sc = (zen_ang + 34'sd256) >>> 9;

	always_comb begin
		az_cl = az_sc;
		if (az_sc < -OUT_PI_A) begin
			az_cl = -OUT_PI_A;
		end else if (az_sc > OUT_PI_A) begin
			az_cl = OUT_PI_A;
		end
		zen_cl = zen_sc;
		if (zen_sc < 34'sd0) begin
			zen_cl = '0;
		end else if (zen_sc > OUT_PI_A) begin
			zen_cl = OUT_PI_A;
		end
	end

	always_comb begin
		origin_w = zen_side;
		radius_w = az_side[W+1:2];
		zen_w    = zen_cl[ZEN_W-1:0];
		az_w     = az_cl[AZ_W-1:0];
		priority if (zen_side) begin
			radius_w = '0;
			zen_w    = '0;
			az_w     = '0;
		end else if (az_side[0]) begin
			// on the z axis
			zen_w = az_side[1] ? '0 : OUT_PI_A[ZEN_W-1:0];
			az_w  = '0;
		end
	end

	assign push     = en && az_v && zen_v;
	assign fifo_din = {origin_w, {PAD_W{1'b0}}, az_w, zen_w, radius_w};

	cts_out_fifo #(.DW(OUT_DW+1)) u_out_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.din      (fifo_din),
		.pop_ready(m_axis_tready),
		.dout     (fifo_dout),
		.stat     (fst)
	);

	assign m_axis_tvalid = fst.not_empty;
	assign m_axis_tdata  = fifo_dout[OUT_DW-1:0];
	assign m_axis_tuser  = fifo_dout[OUT_DW];

	assign radius_o = fifo_dout[W-1:0];
	assign zen_o    = fifo_dout[W+ZEN_W-1:W];
	assign az_o     = fifo_dout[W+ZEN_W+AZ_W-1:W+ZEN_W];

`include "cartesian_to_spherical_top_assert.svh"

	`CTS_ASSERT_SAME(a_origin_flag, m_axis_tvalid, m_axis_tuser == (radius_o == '0), "origin flag and radius disagree")
	`CTS_ASSERT_SAME(a_origin_angles, m_axis_tvalid && m_axis_tuser, zen_o == '0 && az_o == '0, "angles not cleared at origin")
	`CTS_ASSERT_SAME(a_zen_range, m_axis_tvalid, zen_o <= OUT_PI_A[ZEN_W-1:0], "zenith beyond pi")
	`CTS_ASSERT_SAME(a_stall_cause, !s_axis_tready, m_axis_tvalid, "input stalled with no result waiting")

endmodule
